// ===== hw/rtl/linked_table_automaton_player_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the automaton player
// ----------------------------------------------------------------------------
`ifndef LINKED_TABLE_AUTOMATON_PLAYER_ASSERT_SVH
`define LINKED_TABLE_AUTOMATON_PLAYER_ASSERT_SVH

// same-cycle implication
`define LTAP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ltap: same-cycle check failed");

// next-cycle implication
`define LTAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ltap: next-cycle check failed");

`endif

// ===== hw/rtl/ltap_pkg.sv =====
// ----------------------------------------------------------------------------
// ltap_pkg
// Types, codes and constants of the linked-table automaton player.
// ----------------------------------------------------------------------------
package ltap_pkg;

  localparam int MAX_TRANS_DEF  = 128;
  localparam int MAX_STATES_DEF = 32;

  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 7;
  localparam int EVENT_W = 5;
  localparam int STATE_W = 5;
  localparam int LINK_W  = 8;
  localparam int GEN_W   = 4;

  // entry word: {event, target, link}
  localparam int ENTRY_W = EVENT_W + STATE_W + LINK_W;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // generator runs steps 0..10, codes 1,3,..,21
  localparam logic [GEN_W-1:0] GEN_LAST_STEP = 4'd10;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_ENTRY = 2'd0,
    FUNC_WR_HEAD  = 2'd1,
    FUNC_EXT_EV   = 2'd2,
    FUNC_GEN_EV   = 2'd3
  } func_e;

  // status of the shared link/compare unit
  typedef struct packed {
    logic hit;      // entry event equals applied event
    logic link_ok;  // link is nonzero and inside the table
    logic overrun;  // visit budget used up
  } walk_status_t;

endpackage

// ===== hw/rtl/linked_table_automaton_player.sv =====
// ----------------------------------------------------------------------------
// linked_table_automaton_player
// Finite automaton driven by loaded transition chains, one request at a time.
// ----------------------------------------------------------------------------
// Use:
//   Requests enter on s_axis_*; s_axis_tuser carries func (write entry, write
//   head, external event, generated event), s_axis_tdata the table fields.
//   Every request gives exactly one response on m_axis_*.
//   A table write, or an event on a deadlocked block, goes from accept
//   straight to the emit state, which loads the response register. Other
//   events pass the head check state, then the entry state, reading the n
//   chain entries visited (0 to MAX_TRANS) one by one through the single
//   entry memory port, then the emit state. s_axis_tready is high only
//   while the sequencer is idle, so a new request is taken only once the last one has left it.
//   The response register is separate from the sequencer, so a new request is
//   taken while an earlier response still waits; if the receiver stalls, the
//   sequencer holds its finished response until the register frees.
//   Reset clears state, generator step, deadlock flag and the handshake;
//   table memories are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
module linked_table_automaton_player #(
  parameter int MAX_TRANS  = ltap_pkg::MAX_TRANS_DEF,
  parameter int MAX_STATES = ltap_pkg::MAX_STATES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [6:0] index, [11:7] event_code, [16:12] target_state, [24:17] link
  input  logic [ltap_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // [1:0] func
  input  logic [ltap_pkg::FUNC_W-1:0]    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] accepted, [5:1] applied_event, [10:6] state_now, [11] deadlock,
  // [12] walk_overrun
  output logic [ltap_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int TA = (MAX_TRANS  > 1) ? $clog2(MAX_TRANS)  : 1;
  localparam int SA = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int VW = $clog2(MAX_TRANS + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HEAD  = 2'd1;
  localparam logic [1:0] ST_ENTRY = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // request fields
  logic [ltap_pkg::INDEX_W-1:0] in_index;
  logic [ltap_pkg::EVENT_W-1:0] in_event;
  logic [ltap_pkg::STATE_W-1:0] in_target;
  logic [ltap_pkg::LINK_W-1:0]  in_link;
  ltap_pkg::func_e              in_func;

  assign in_index  = s_axis_tdata_i[6:0];
  assign in_event  = s_axis_tdata_i[11:7];
  assign in_target = s_axis_tdata_i[16:12];
  assign in_link   = s_axis_tdata_i[24:17];
  assign in_func   = ltap_pkg::func_e'(s_axis_tuser_i);

  logic [1:0]                   state_q, state_d;
  logic [ltap_pkg::STATE_W-1:0] cur_q, cur_d;
  logic [ltap_pkg::GEN_W-1:0]   gen_q, gen_d;
  logic                         dl_q, dl_d;
  logic [ltap_pkg::EVENT_W-1:0] ev_q, ev_d;
  logic                         acc_q, acc_d;
  logic                         over_q, over_d;
  logic                         oor_q, oor_d;   // current state beyond head table
  logic [VW-1:0]                visited_q, visited_d;
  logic                         m_valid_q, m_valid_d;
  logic [ltap_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;

  // memory ports
  logic                          ent_we, ent_re, head_we, head_re;
  logic [ltap_pkg::ENTRY_W-1:0]  ent_rdata;
  logic [ltap_pkg::LINK_W-1:0]   head_rdata;
  logic [TA-1:0]                 ent_raddr;

  logic [ltap_pkg::EVENT_W-1:0]  ent_event;
  logic [ltap_pkg::STATE_W-1:0]  ent_target;
  logic [ltap_pkg::LINK_W-1:0]   ent_link;
  assign {ent_event, ent_target, ent_link} = ent_rdata;

  // one link path feeds both the range check and the next read address
  logic [ltap_pkg::LINK_W-1:0]   link_sel;
  ltap_pkg::walk_status_t        walk;

  assign link_sel  = (state_q == ST_HEAD) ? head_rdata : ent_link;
  assign ent_raddr = TA'(link_sel - 8'd1);

  // generator: clamp, code = 2*step+1, wrap after last step
  logic [ltap_pkg::GEN_W-1:0]   gen_step;
  logic [ltap_pkg::EVENT_W-1:0] gen_code;
  logic [ltap_pkg::GEN_W-1:0]   gen_next;

  always_comb begin
    gen_step = (gen_q > ltap_pkg::GEN_LAST_STEP) ? ltap_pkg::GEN_LAST_STEP : gen_q;
    gen_code = {gen_step, 1'b1};
    gen_next = (gen_step >= ltap_pkg::GEN_LAST_STEP) ? '0 : gen_step + 4'd1;
  end

  logic in_fire;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  ltap_tables #(
    .MAX_TRANS (MAX_TRANS),
    .MAX_STATES(MAX_STATES)
  ) u_tables (
    .clk_i       (clk_i),
    .ent_we_i    (ent_we),
    .ent_waddr_i (TA'(in_index)),
    .ent_wdata_i ({in_event, in_target, in_link}),
    .ent_re_i    (ent_re),
    .ent_raddr_i (ent_raddr),
    .ent_rdata_o (ent_rdata),
    .head_we_i   (head_we),
    .head_waddr_i(SA'(in_index)),
    .head_wdata_i(in_link),
    .head_re_i   (head_re),
    .head_raddr_i(SA'(cur_q)),
    .head_rdata_o(head_rdata)
  );

  ltap_matcher #(
    .MAX_TRANS(MAX_TRANS)
  ) u_matcher (
    .entry_event_i  (ent_event),
    .applied_event_i(ev_q),
    .link_i         (link_sel),
    .visited_i      (visited_q),
    .status_o       (walk)
  );

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    gen_d     = gen_q;
    dl_d      = dl_q;
    ev_d      = ev_q;
    acc_d     = acc_q;
    over_d    = over_q;
    oor_d     = oor_q;
    visited_d = visited_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    ent_we    = 1'b0;
    ent_re    = 1'b0;
    head_we   = 1'b0;
    head_re   = 1'b0;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          acc_d   = 1'b0;
          over_d  = 1'b0;
          ev_d    = '0;
          state_d = ST_EMIT;
          case (in_func)
            ltap_pkg::FUNC_WR_ENTRY: ent_we  = (32'(in_index) < MAX_TRANS);
            ltap_pkg::FUNC_WR_HEAD:  head_we = (32'(in_index) < MAX_STATES);
            default: begin
              if (!dl_q) begin
                if (in_func == ltap_pkg::FUNC_GEN_EV) begin
                  ev_d  = gen_code;
                  gen_d = gen_next;
                end else begin
                  ev_d = in_event;
                end
                head_re = 1'b1;
                oor_d   = !(32'(cur_q) < MAX_STATES);
                state_d = ST_HEAD;
              end
            end
          endcase
        end
      end
      ST_HEAD: begin
        if (oor_q || head_rdata == '0) begin
          dl_d    = 1'b1;
          state_d = ST_EMIT;
        end else if (!walk.link_ok) begin
          state_d = ST_EMIT;
        end else begin
          ent_re    = 1'b1;
          visited_d = VW'(1);
          state_d   = ST_ENTRY;
        end
      end
      ST_ENTRY: begin
        if (walk.hit) begin
          cur_d   = ent_target;
          acc_d   = 1'b1;
          state_d = ST_EMIT;
        end else if (!walk.link_ok) begin
          state_d = ST_EMIT;
        end else if (walk.overrun) begin
          over_d  = 1'b1;
          state_d = ST_EMIT;
        end else begin
          ent_re    = 1'b1;
          visited_d = visited_q + VW'(1);
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'b000, over_q, dl_q, cur_q, ev_q, acc_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= '0;
      gen_q     <= '0;
      dl_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      gen_q     <= gen_d;
      dl_q      <= dl_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q      <= ev_d;
    acc_q     <= acc_d;
    over_q    <= over_d;
    oor_q     <= oor_d;
    visited_q <= visited_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== hw/rtl/ltap_tables.sv =====
// ----------------------------------------------------------------------------
// ltap_tables
// Transition entry memory and state head memory, registered reads.
// ----------------------------------------------------------------------------
module ltap_tables #(
  parameter int MAX_TRANS  = ltap_pkg::MAX_TRANS_DEF,
  parameter int MAX_STATES = ltap_pkg::MAX_STATES_DEF,
  localparam int TA = (MAX_TRANS  > 1) ? $clog2(MAX_TRANS)  : 1,
  localparam int SA = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1
) (
  input  logic                        clk_i,
  input  logic                        ent_we_i,
  input  logic [TA-1:0]               ent_waddr_i,
  input  logic [ltap_pkg::ENTRY_W-1:0] ent_wdata_i,
  input  logic                        ent_re_i,
  input  logic [TA-1:0]               ent_raddr_i,
  output logic [ltap_pkg::ENTRY_W-1:0] ent_rdata_o,
  input  logic                        head_we_i,
  input  logic [SA-1:0]               head_waddr_i,
  input  logic [ltap_pkg::LINK_W-1:0]  head_wdata_i,
  input  logic                        head_re_i,
  input  logic [SA-1:0]               head_raddr_i,
  output logic [ltap_pkg::LINK_W-1:0]  head_rdata_o
);

  logic [ltap_pkg::ENTRY_W-1:0] ent_mem [MAX_TRANS];
  logic [ltap_pkg::LINK_W-1:0]  head_mem [MAX_STATES];

  always_ff @(posedge clk_i) begin
    if (ent_we_i) begin
      ent_mem[ent_waddr_i] <= ent_wdata_i;
    end
    if (ent_re_i) begin
      ent_rdata_o <= ent_mem[ent_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we_i) begin
      head_mem[head_waddr_i] <= head_wdata_i;
    end
    if (head_re_i) begin
      head_rdata_o <= head_mem[head_raddr_i];
    end
  end

endmodule

// ===== hw/rtl/ltap_matcher.sv =====
// ----------------------------------------------------------------------------
// ltap_matcher
// Shared compare unit: event match, link range check, visit budget check.
// ----------------------------------------------------------------------------
module ltap_matcher #(
  parameter int MAX_TRANS = ltap_pkg::MAX_TRANS_DEF,
  localparam int VW = $clog2(MAX_TRANS + 1)
) (
  input  logic [ltap_pkg::EVENT_W-1:0] entry_event_i,
  input  logic [ltap_pkg::EVENT_W-1:0] applied_event_i,
  input  logic [ltap_pkg::LINK_W-1:0]  link_i,
  input  logic [VW-1:0]                visited_i,
  output ltap_pkg::walk_status_t       status_o
);

  always_comb begin
    status_o.hit     = (entry_event_i == applied_event_i);
    status_o.link_ok = (link_i != '0) && (32'(link_i) <= MAX_TRANS);
    status_o.overrun = (32'(visited_i) >= MAX_TRANS);
  end

endmodule

// ===== hw/rtl/ltap_checker.sv =====
// ----------------------------------------------------------------------------
// ltap_checker
// Port-level checks of the automaton player, bound to the top level.
// ----------------------------------------------------------------------------
`include "linked_table_automaton_player_assert.svh"

module ltap_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // stalled response holds
  `LTAP_ASSERT_NEXT(a_resp_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // one request in flight: busy right after an accept
  `LTAP_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // a deadlocked automaton never accepts an event and never reports an overrun
  `LTAP_ASSERT_IMPL(a_dead_no_acc, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[11], !m_axis_tdata_o[0] && !m_axis_tdata_o[12])

  // an overrun walk found no match
  `LTAP_ASSERT_IMPL(a_over_no_acc, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[12], !m_axis_tdata_o[0])

endmodule

bind linked_table_automaton_player ltap_checker u_ltap_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
